@@ hw/rtl/quadrature_sine_lookup_interp_top_macros.svh @@
// assertion macros shared by the sine/cosine lookup block
`ifndef QUADRATURE_SINE_LOOKUP_INTERP_TOP_MACROS_SVH
`define QUADRATURE_SINE_LOOKUP_INTERP_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SQLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain condition that holds at every sampled edge out of reset
`define SQLI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

@@ hw/rtl/sqli_pkg.sv @@
// shared constants, types and table generation for the sine/cosine lookup block
`default_nettype none

package sqli_pkg;

  localparam int unsigned TableBitsDef     = 9;
  localparam int unsigned FracBitsDef      = 20;
  localparam int unsigned AmplitudeBitsDef = 30;

  localparam int unsigned PhaseW = 32;
  localparam int unsigned ValW   = 32;

  // pi in unsigned q4.60
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

  typedef logic signed [ValW-1:0] val_t;

  // two neighboring table points
  typedef struct packed {
    val_t a;
    val_t b;
  } pair_t;

  // (x * y) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  // sin(2*pi*j/2^tb) scaled by 2^aw, rounded; j within the first quarter turn
  // evaluated at elaboration only, taylor series to the 29th power
  function automatic val_t quarter_sin(input int unsigned j, input int unsigned tb,
                                       input int unsigned aw);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = ((PiQ60 >> 1) >> (tb - 2)) * 64'(j);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd110; sum = sum - term;
    term = mul_q60(term, x2) / 64'd156; sum = sum + term;
    term = mul_q60(term, x2) / 64'd210; sum = sum - term;
    term = mul_q60(term, x2) / 64'd272; sum = sum + term;
    term = mul_q60(term, x2) / 64'd342; sum = sum - term;
    term = mul_q60(term, x2) / 64'd420; sum = sum + term;
    term = mul_q60(term, x2) / 64'd506; sum = sum - term;
    term = mul_q60(term, x2) / 64'd600; sum = sum + term;
    term = mul_q60(term, x2) / 64'd702; sum = sum - term;
    term = mul_q60(term, x2) / 64'd812; sum = sum + term;
    return val_t'((sum + (64'd1 << (59 - aw))) >> (60 - aw));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/quadrature_sine_lookup_interp_top.sv @@
// top level of the quadrature sine/cosine lookup with linear interpolation
//
// usage:
//   drive phase_i and raise start; the word is taken at the rising edge where
//   start is high and busy is low. busy stays low, so a new phase word can be
//   given at every clock edge.
//   bits above the table index are ignored; the index selects a point of the
//   wave and the low bits interpolate linearly toward the next point.
//   each result appears on sine_out_o and cosine_out_o for exactly one cycle,
//   marked by done_o, once the word has passed the input register, table read,
//   slope, multiply and add registers.
//   one result per cycle sustained.
//   the receiver cannot stall; results are taken in the cycle they show.
//   reset clears the valid pipeline only; the table is constant logic, so the
//   block works from the first cycle after reset.
`default_nettype none

module quadrature_sine_lookup_interp_top #(
  parameter int unsigned TABLE_BITS     = sqli_pkg::TableBitsDef,
  parameter int unsigned FRAC_BITS      = sqli_pkg::FracBitsDef,
  parameter int unsigned AMPLITUDE_BITS = sqli_pkg::AmplitudeBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sqli_pkg::PhaseW-1:0]    phase_i,
  output logic                                done_o,
  output logic signed [sqli_pkg::ValW-1:0]    sine_out_o,
  output logic signed [sqli_pkg::ValW-1:0]    cosine_out_o
);

  `include "quadrature_sine_lookup_interp_top_macros.svh"

  localparam int unsigned Latency = 5;
  localparam sqli_pkg::val_t AmpLim = sqli_pkg::val_t'(64'd1 << AMPLITUDE_BITS);

  logic                           accept;
  logic [sqli_pkg::PhaseW-1:0]    phase_q;
  logic [Latency-1:0]             vld_d, vld_q;

  sqli_pkg::pair_t                sin_pair;
  sqli_pkg::pair_t                cos_pair;
  logic [FRAC_BITS-1:0]           frac;
  sqli_pkg::val_t                 sin_val;
  sqli_pkg::val_t                 cos_val;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q <= phase_i;
    end
  end

  // one valid bit per pipeline stage
  assign vld_d = {vld_q[Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  sqli_lookup #(
    .TABLE_BITS     (TABLE_BITS),
    .FRAC_BITS      (FRAC_BITS),
    .AMPLITUDE_BITS (AMPLITUDE_BITS)
  ) u_lookup (
    .clk_i      (clk_i),
    .phase_i    (phase_q),
    .sin_pair_o (sin_pair),
    .cos_pair_o (cos_pair),
    .frac_o     (frac)
  );

  sqli_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp_sin (
    .clk_i  (clk_i),
    .pair_i (sin_pair),
    .frac_i (frac),
    .val_o  (sin_val)
  );

  sqli_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp_cos (
    .clk_i  (clk_i),
    .pair_i (cos_pair),
    .frac_i (frac),
    .val_o  (cos_val)
  );

  assign done_o       = vld_q[Latency-1];
  assign sine_out_o   = sin_val;
  assign cosine_out_o = cos_val;

  `SQLI_ASSERT_IMP(accept_to_done_a, accept, ##Latency done_o, "accepted word gave no result")
  `SQLI_ASSERT_IMP(done_from_accept_a, done_o, $past(accept, Latency), "result without a word")
  `SQLI_ASSERT_IMP(sine_range_a, done_o, (sine_out_o <= AmpLim) && (sine_out_o >= -AmpLim), "sine out of range")
  `SQLI_ASSERT_IMP(cosine_range_a, done_o, (cosine_out_o <= AmpLim) && (cosine_out_o >= -AmpLim), "cosine out of range")

endmodule

`default_nettype wire

@@ hw/rtl/sqli_lookup.sv @@
// quarter-wave table lookup of both neighboring points for sine and cosine
`default_nettype none

module sqli_lookup #(
  parameter int unsigned TABLE_BITS     = sqli_pkg::TableBitsDef,
  parameter int unsigned FRAC_BITS      = sqli_pkg::FracBitsDef,
  parameter int unsigned AMPLITUDE_BITS = sqli_pkg::AmplitudeBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic [sqli_pkg::PhaseW-1:0]      phase_i,
  output sqli_pkg::pair_t                       sin_pair_o,
  output sqli_pkg::pair_t                       cos_pair_o,
  output logic [FRAC_BITS-1:0]                  frac_o
);

  localparam int unsigned N  = 1 << TABLE_BITS;
  localparam int unsigned Q  = N / 4;
  localparam int unsigned QW = TABLE_BITS - 1;

  // first quarter of the wave, 0 .. pi/2 inclusive
  sqli_pkg::val_t qtab [Q+1];

  for (genvar gi = 0; gi <= Q; gi++) begin : g_qtab
    localparam sqli_pkg::val_t QVal = sqli_pkg::quarter_sin(gi, TABLE_BITS, AMPLITUDE_BITS);
    assign qtab[gi] = QVal;
  end

  logic [63:0]            phase_ext;
  logic [TABLE_BITS-1:0]  sidx;
  logic [TABLE_BITS-1:0]  idx [4];
  sqli_pkg::val_t         rdv [4];

  sqli_pkg::pair_t        sin_pair_d, sin_pair_q;
  sqli_pkg::pair_t        cos_pair_d, cos_pair_q;
  logic [FRAC_BITS-1:0]   frac_d, frac_q;

  assign phase_ext = 64'(phase_i);
  assign sidx      = phase_ext[FRAC_BITS +: TABLE_BITS];
  assign frac_d    = phase_i[FRAC_BITS-1:0];

  // entry N equals entry 0, so k+1 simply wraps
  assign idx[0] = sidx;
  assign idx[1] = sidx + TABLE_BITS'(1);
  assign idx[2] = sidx + TABLE_BITS'(Q);
  assign idx[3] = sidx + TABLE_BITS'(Q + 1);

  // fold the full-wave index onto the quarter table
  always_comb begin
    logic [1:0]     quad;
    logic [QW-1:0]  r;
    logic [QW-1:0]  qi;
    sqli_pkg::val_t v;
    for (int i = 0; i < 4; i++) begin
      quad   = idx[i][TABLE_BITS-1 -: 2];
      r      = QW'(idx[i][TABLE_BITS-3:0]);
      qi     = quad[0] ? (QW'(Q) - r) : r;
      v      = qtab[qi];
      rdv[i] = quad[1] ? -v : v;
    end
  end

  assign sin_pair_d = '{a: rdv[0], b: rdv[1]};
  assign cos_pair_d = '{a: rdv[2], b: rdv[3]};

  always_ff @(posedge clk_i) begin
    sin_pair_q <= sin_pair_d;
    cos_pair_q <= cos_pair_d;
    frac_q     <= frac_d;
  end

  assign sin_pair_o = sin_pair_q;
  assign cos_pair_o = cos_pair_q;
  assign frac_o     = frac_q;

endmodule

`default_nettype wire

@@ hw/rtl/sqli_interp.sv @@
// linear interpolation between two table points: slope, product, floored add
`default_nettype none

module sqli_interp #(
  parameter int unsigned FRAC_BITS = sqli_pkg::FracBitsDef
) (
  input  wire logic                  clk_i,
  input  wire sqli_pkg::pair_t       pair_i,
  input  wire logic [FRAC_BITS-1:0]  frac_i,
  output sqli_pkg::val_t             val_o
);

  localparam int unsigned PW = sqli_pkg::ValW + FRAC_BITS + 1;

  sqli_pkg::val_t          diff_d, diff_q;
  sqli_pkg::val_t          base_q, base2_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic signed [PW-1:0]    prod_d, prod_q;
  sqli_pkg::val_t          val_d, val_q;

  assign diff_d = pair_i.b - pair_i.a;

  // signed slope times unsigned fraction
  assign prod_d = PW'(diff_q) * PW'($signed({1'b0, frac_q}));

  // arithmetic shift floors toward minus infinity
  assign val_d = base2_q + sqli_pkg::val_t'(prod_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    base_q  <= pair_i.a;
    frac_q  <= frac_i;
    prod_q  <= prod_d;
    base2_q <= base_q;
    val_q   <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire
